FILE: src/indexed_min_heap_decrease_key_defines.svh
// Assertion macros shared by the heap checker.
`ifndef INDEXED_MIN_HEAP_DECREASE_KEY_DEFINES_SVH
`define INDEXED_MIN_HEAP_DECREASE_KEY_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define IMH_ASSERT_IMP(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (con)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define IMH_ASSERT_NXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (con)) else $error(msg);

`endif

FILE: src/imh_pkg.sv
// Shared constants and codes for the indexed min-heap.
package imh_pkg;
  localparam int KEY_W       = 10;
  localparam int KEY_SPACE   = 1024;
  localparam int IN_VALUE_W  = 48;
  localparam int OUT_VALUE_W = 48;
  localparam int STATUS_W    = 3;
  localparam int REMAIN_W    = 11;
  localparam int MODE_W      = 2;
  localparam int IN_TDATA_W  = 112;
  localparam int OUT_TDATA_W = 72;

  localparam logic [MODE_W-1:0] MODE_INSERT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DECREASE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_POP      = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DUP    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 3'd4;
endpackage

FILE: src/imh_alu.sv
// Shared subtract/compare unit: difference and a-less-than-b from the borrow.
module imh_alu #(
  parameter int W = 48
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] diff,
  output logic         lt
);
  logic [W:0] full;

  assign full = {1'b0, a} - {1'b0, b};
  assign diff = full[W-1:0];
  assign lt   = full[W];
endmodule

FILE: src/imh_slot_ram.sv
// Heap slot memory: one write port, two registered read ports.
module imh_slot_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int VW    = 48
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [imh_pkg::KEY_W-1:0] wkey,
  input  logic [VW-1:0]             wval,
  input  logic [AW-1:0]             raddr_a,
  input  logic [AW-1:0]             raddr_b,
  output logic [imh_pkg::KEY_W-1:0] rkey_a,
  output logic [VW-1:0]             rval_a,
  output logic [imh_pkg::KEY_W-1:0] rkey_b,
  output logic [VW-1:0]             rval_b
);
  import imh_pkg::*;

  logic [KEY_W-1:0] keys [DEPTH];
  logic [VW-1:0]    vals [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      keys[waddr] <= wkey;
      vals[waddr] <= wval;
    end
    rkey_a <= keys[raddr_a];
    rval_a <= vals[raddr_a];
    rkey_b <= keys[raddr_b];
    rval_b <= vals[raddr_b];
  end
endmodule

FILE: src/imh_key_map.sv
// Key-to-slot map: present bit and slot index per key, registered read.
module imh_key_map #(
  parameter int PW = 10
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [imh_pkg::KEY_W-1:0] waddr,
  input  logic                      wpresent,
  input  logic [PW-1:0]             wpos,
  input  logic [imh_pkg::KEY_W-1:0] raddr,
  output logic                      rpresent,
  output logic [PW-1:0]             rpos
);
  import imh_pkg::*;

  logic [PW:0] map [KEY_SPACE];

  always_ff @(posedge clk) begin
    if (we) begin
      map[waddr] <= {wpresent, wpos};
    end
    {rpresent, rpos} <= map[raddr];
  end
endmodule

FILE: src/indexed_min_heap_decrease_key.sv
// Top level: indexed binary min-heap with insert, decrease-key and pop-min.
//
// Input channel s_*: one transfer is one operation. s_tuser carries the mode
// (insert, decrease, pop); s_tdata carries key, value and delta.
// Output channel m_*: exactly one transfer per operation, with the popped
// pair (zero unless a pop succeeded), a status code and the entry count.
//
// Structure: an operation is handled by a small sequencer around one shared
// subtract/compare unit and two memories (heap slots, key map). Each
// operation starts with a key map lookup; each sift level reads the parent
// and compares going up, or reads the children, picks a child and compares
// going down; a decrease adds a subtract step. Failing operations go from
// the lookup straight to the result. One operation is in flight at a time:
// s_tready is high only when the block is idle, in the cycle after the
// result transfer.
//
// Reset: rst (synchronous) empties the heap, then a clearing pass walks the
// 1024-entry key map, one key per cycle, before s_tready first rises.
// Stalls: a result stays on m_tdata with m_tvalid high until m_tready.
module indexed_min_heap_decrease_key #(
  parameter int CAPACITY   = 1024,
  parameter int VALUE_BITS = 48
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [imh_pkg::MODE_W-1:0]      s_tuser,  // mode
  // item_key[9:0], item_value[57:10], delta[105:58], zero pad
  input  logic [imh_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // out_key[9:0], out_value[57:10], status[60:58], remaining[71:61]
  output logic [imh_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import imh_pkg::*;

  localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = PW + 2;
  localparam int UW = (VALUE_BITS > IN_VALUE_W) ? VALUE_BITS : IN_VALUE_W;

  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_LOOK    = 4'd2;
  localparam logic [3:0] S_DEC     = 4'd3;
  localparam logic [3:0] S_UP_RD   = 4'd4;
  localparam logic [3:0] S_UP_CMP  = 4'd5;
  localparam logic [3:0] S_DN_RD   = 4'd6;
  localparam logic [3:0] S_DN_PICK = 4'd7;
  localparam logic [3:0] S_DN_CMP  = 4'd8;
  localparam logic [3:0] S_OUT     = 4'd9;

  logic [3:0]            state;
  logic [KEY_W-1:0]      clr_idx;
  logic [CW-1:0]         count;
  logic [MODE_W-1:0]     op_mode;
  logic [IN_VALUE_W-1:0] op_delta;
  logic [KEY_W-1:0]      hold_key;
  logic [VALUE_BITS-1:0] hold_val;
  logic [PW-1:0]         pos;
  logic [KEY_W-1:0]      pick_key;
  logic [VALUE_BITS-1:0] pick_val;
  logic [PW-1:0]         pick_idx;
  logic [KEY_W-1:0]      out_key;
  logic [VALUE_BITS-1:0] out_val;
  logic [STATUS_W-1:0]   status;

  // memory ports
  logic                  heap_we;
  logic [KEY_W-1:0]      heap_wkey;
  logic [VALUE_BITS-1:0] heap_wval;
  logic [PW-1:0]         heap_ra, heap_rb;
  logic [KEY_W-1:0]      rkey_a, rkey_b;
  logic [VALUE_BITS-1:0] rval_a, rval_b;
  logic                  km_we, km_wpresent, km_rpresent;
  logic [KEY_W-1:0]      km_waddr;
  logic [PW-1:0]         km_wpos, km_rpos;

  // shared unit
  logic [UW-1:0] alu_a, alu_b, alu_diff;
  logic          alu_lt;

  logic [PW-1:0] parent;
  logic [LW-1:0] left, right;
  logic          left_in, right_in;
  logic [CW-1:0] count_dec;

  assign parent    = PW'((pos - PW'(1)) >> 1);
  assign left      = LW'({pos, 1'b1});
  assign right     = left + LW'(1);
  assign left_in   = left < LW'(count);
  assign right_in  = right < LW'(count);
  assign count_dec = count - CW'(1);

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);
  assign m_tdata  = {REMAIN_W'(count), status, OUT_VALUE_W'(out_val), out_key};

  imh_alu #(.W(UW)) u_alu (
    .a(alu_a), .b(alu_b), .diff(alu_diff), .lt(alu_lt)
  );

  imh_slot_ram #(.DEPTH(CAPACITY), .AW(PW), .VW(VALUE_BITS)) u_slots (
    .clk(clk), .we(heap_we), .waddr(pos), .wkey(heap_wkey), .wval(heap_wval),
    .raddr_a(heap_ra), .raddr_b(heap_rb),
    .rkey_a(rkey_a), .rval_a(rval_a), .rkey_b(rkey_b), .rval_b(rval_b)
  );

  imh_key_map #(.PW(PW)) u_keymap (
    .clk(clk), .we(km_we), .waddr(km_waddr), .wpresent(km_wpresent),
    .wpos(km_wpos), .raddr(s_tdata[KEY_W-1:0]),
    .rpresent(km_rpresent), .rpos(km_rpos)
  );

  // shared unit operands
  always_comb begin
    alu_a = UW'(hold_val);
    alu_b = UW'(rval_a);
    unique case (state)
      S_DEC: begin
        alu_a = UW'(rval_a);
        alu_b = UW'(op_delta);
      end
      S_DN_PICK: begin
        alu_a = UW'(rval_b);
        alu_b = UW'(rval_a);
      end
      S_DN_CMP: begin
        alu_a = UW'(pick_val);
        alu_b = UW'(hold_val);
      end
      default: ;
    endcase
  end

  // read addresses
  always_comb begin
    heap_ra = '0;
    heap_rb = '0;
    unique case (state)
      S_IDLE:  heap_rb = PW'(count_dec);
      S_LOOK:  heap_ra = km_rpos;
      S_UP_RD: heap_ra = parent;
      S_DN_RD: begin
        heap_ra = PW'(left);
        heap_rb = PW'(right);
      end
      default: ;
    endcase
  end

  // writes: a slot write at pos always pairs with a key map update
  always_comb begin
    heap_we     = 1'b0;
    heap_wkey   = hold_key;
    heap_wval   = hold_val;
    km_we       = 1'b0;
    km_waddr    = hold_key;
    km_wpresent = 1'b1;
    km_wpos     = pos;
    unique case (state)
      S_CLEAR: begin
        km_we       = 1'b1;
        km_waddr    = clr_idx;
        km_wpresent = 1'b0;
      end
      S_LOOK: begin
        if (op_mode == MODE_POP && count != '0) begin
          km_we       = 1'b1;
          km_waddr    = rkey_a;
          km_wpresent = 1'b0;
        end
      end
      S_UP_RD: begin
        heap_we = (pos == '0);
        km_we   = (pos == '0);
      end
      S_UP_CMP: begin
        heap_we = 1'b1;
        km_we   = 1'b1;
        if (alu_lt) begin
          heap_wkey = rkey_a;
          heap_wval = rval_a;
          km_waddr  = rkey_a;
        end
      end
      S_DN_RD: begin
        heap_we = !left_in;
        km_we   = !left_in;
      end
      S_DN_CMP: begin
        heap_we = 1'b1;
        km_we   = 1'b1;
        if (alu_lt) begin
          heap_wkey = pick_key;
          heap_wval = pick_val;
          km_waddr  = pick_key;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
      count   <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + KEY_W'(1);
          if (clr_idx == KEY_W'(KEY_SPACE - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (s_tvalid) begin
            op_mode  <= s_tuser;
            op_delta <= s_tdata[KEY_W+2*IN_VALUE_W-1:KEY_W+IN_VALUE_W];
            hold_key <= s_tdata[KEY_W-1:0];
            hold_val <= VALUE_BITS'(s_tdata[KEY_W+IN_VALUE_W-1:KEY_W]);
            out_key  <= '0;
            out_val  <= '0;
            status   <= ST_OK;
            state    <= S_LOOK;
          end
        end
        S_LOOK: begin
          state <= S_OUT;
          unique case (op_mode)
            MODE_INSERT: begin
              if (km_rpresent) begin
                status <= ST_DUP;
              end else if (count == CW'(CAPACITY)) begin
                status <= ST_FULL;
              end else begin
                pos   <= PW'(count);
                count <= count + CW'(1);
                state <= S_UP_RD;
              end
            end
            MODE_DECREASE: begin
              if (!km_rpresent) begin
                status <= ST_ABSENT;
              end else if (CW'(km_rpos) < count) begin
                pos   <= km_rpos;
                state <= S_DEC;
              end
            end
            MODE_POP: begin
              if (count == '0) begin
                status <= ST_EMPTY;
              end else begin
                out_key  <= rkey_a;
                out_val  <= rval_a;
                count    <= count_dec;
                hold_key <= rkey_b;
                hold_val <= rval_b;
                pos      <= '0;
                if (count_dec != '0) state <= S_DN_RD;
              end
            end
            default: ;
          endcase
        end
        S_DEC: begin
          // saturate at zero when delta reaches the value
          hold_val <= alu_lt ? '0 : VALUE_BITS'(alu_diff);
          state    <= S_UP_RD;
        end
        S_UP_RD: begin
          state <= (pos == '0) ? S_OUT : S_UP_CMP;
        end
        S_UP_CMP: begin
          if (alu_lt) begin
            pos   <= parent;
            state <= S_UP_RD;
          end else begin
            state <= S_OUT;
          end
        end
        S_DN_RD: begin
          state <= left_in ? S_DN_PICK : S_OUT;
        end
        S_DN_PICK: begin
          // right child only if strictly smaller
          if (right_in && alu_lt) begin
            pick_key <= rkey_b;
            pick_val <= rval_b;
            pick_idx <= PW'(right);
          end else begin
            pick_key <= rkey_a;
            pick_val <= rval_a;
            pick_idx <= PW'(left);
          end
          state <= S_DN_CMP;
        end
        S_DN_CMP: begin
          if (alu_lt) begin
            pos   <= pick_idx;
            state <= S_DN_RD;
          end else begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (m_tready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: src/imh_checker.sv
// Port-level checker for the heap, bound to the top level.
`include "indexed_min_heap_decrease_key_defines.svh"

module imh_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [imh_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import imh_pkg::*;

  `IMH_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
  `IMH_ASSERT_IMP(a_one_op, m_tvalid, !s_tready, "input taken while a result waits")
  `IMH_ASSERT_NXT(a_busy, s_tvalid && s_tready, !s_tready && !m_tvalid, "no work cycle")
  `IMH_ASSERT_IMP(a_empty_zero, m_tvalid && m_tdata[60:58] == ST_EMPTY, m_tdata[71:61] == '0 && m_tdata[57:0] == '0, "empty pop not zero")
endmodule

bind indexed_min_heap_decrease_key imh_checker u_imh_checker (.*);
